FILE: rtl/apm_pkg.sv
// Shared types and constants of the AQI breakpoint mapper.
// Holds the PM2.5 and PM10 breakpoint tables and the stage payload structs.
// No dependencies.
package apm_pkg;

  localparam int TABLE_ROWS = 7;
  localparam int IDX_W      = $clog2(TABLE_ROWS);

  localparam int CONC_W = 16;   // signed input concentration
  localparam int DIFF_W = 15;   // C - Cl, never negative on a valid item
  localparam int CLO_W  = 13;
  localparam int DEN_W  = 11;   // Ch - Cl
  localparam int ILO_W  = 9;
  localparam int DI_W   = 7;    // Ih - Il
  localparam int NUM_W  = DIFF_W + DI_W;   // (Ih - Il) * (C - Cl)
  localparam int REM_W  = NUM_W + 1;       // 2 * num + den
  localparam int DIV_W  = DEN_W + 1;       // 2 * den
  localparam int Q_W    = 9;               // quotient kept below 512
  localparam int AQI_W  = 10;
  localparam int DIV_STEPS = 3;            // quotient bits per divider stage

  localparam logic [AQI_W-1:0] AQI_MAX     = AQI_W'(500);
  localparam logic [AQI_W-1:0] AQI_INVALID = '1;

  typedef struct packed {
    logic [CLO_W-1:0] c_lo;
    logic [DEN_W-1:0] den;
    logic [ILO_W-1:0] i_lo;
    logic [DI_W-1:0]  di;
  } seg_t;

  typedef seg_t seg_tab_t [TABLE_ROWS];

  // PM2.5 in tenths of ug/m3
  localparam seg_tab_t PM25_TAB = '{
    '{c_lo: 13'd0,    den: 11'd120,  i_lo: 9'd0,   di: 7'd50},
    '{c_lo: 13'd121,  den: 11'd233,  i_lo: 9'd51,  di: 7'd49},
    '{c_lo: 13'd355,  den: 11'd199,  i_lo: 9'd101, di: 7'd49},
    '{c_lo: 13'd555,  den: 11'd949,  i_lo: 9'd151, di: 7'd49},
    '{c_lo: 13'd1505, den: 11'd999,  i_lo: 9'd201, di: 7'd99},
    '{c_lo: 13'd2505, den: 11'd999,  i_lo: 9'd301, di: 7'd99},
    '{c_lo: 13'd3505, den: 11'd1499, i_lo: 9'd401, di: 7'd99}
  };

  // PM10 in whole ug/m3
  localparam seg_tab_t PM10_TAB = '{
    '{c_lo: 13'd0,   den: 11'd54, i_lo: 9'd0,   di: 7'd50},
    '{c_lo: 13'd55,  den: 11'd99, i_lo: 9'd51,  di: 7'd49},
    '{c_lo: 13'd155, den: 11'd99, i_lo: 9'd101, di: 7'd49},
    '{c_lo: 13'd255, den: 11'd99, i_lo: 9'd151, di: 7'd49},
    '{c_lo: 13'd355, den: 11'd69, i_lo: 9'd201, di: 7'd99},
    '{c_lo: 13'd425, den: 11'd79, i_lo: 9'd301, di: 7'd99},
    '{c_lo: 13'd505, den: 11'd99, i_lo: 9'd401, di: 7'd99}
  };

  // After segment lookup
  typedef struct packed {
    logic              invalid;
    logic [DIFF_W-1:0] diff;
    logic [DEN_W-1:0]  den;
    logic [ILO_W-1:0]  i_lo;
    logic [DI_W-1:0]   di;
  } seg_pl_t;

  // Through the divider: quotient of rem / (2 * den), rounded half up
  typedef struct packed {
    logic              invalid;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  dvs;
    logic [Q_W-1:0]    quot;
    logic [ILO_W-1:0]  i_lo;
  } div_pl_t;

endpackage

FILE: rtl/aqi_piecewise_mapper_top.sv
// US EPA AQI breakpoint interpolation, top level.
// Depends on apm_pkg, apm_seg_lookup, apm_scale and apm_div_stage.
//
// Usage:
//   Slave channel: s_axis_tdata carries the signed concentration, s_axis_tuser
//   selects the table (0 = PM2.5 in tenths, 1 = PM10 in whole ug/m3).
//   Master channel: m_axis_tdata carries the signed 10-bit index, 0..500, or -1
//   for a negative concentration. One result transfer per input transfer, in order.
//   From an accepted input transfer to tvalid on the master side an item passes through
//   segment lookup, scale multiply, three divider stages of three quotient
//   bits each, and the rounding/clamp output register. Throughput is one item
//   per cycle while m_axis_tready stays high; the three-stage divider sets the depth.
//   Every stage has its own valid bit and takes new data whenever it is empty or
//   its successor moves, so bubbles close up under a stall and a held result
//   never blocks accepting input while any stage is free.
//   When the receiver stalls, the result stays on m_axis_tdata unchanged; once
//   all six stages are full, s_axis_tready drops.
//   Reset (rst_ni low, asynchronous) empties every stage; nothing else is kept.
module aqi_piecewise_mapper_top #(
  parameter int SEGMENTS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] concentration
  input  logic [0:0]  s_axis_tuser,   // [0] table select (0 = PM2.5, 1 = PM10)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [9:0] aqi, [15:10] zero
);

  // Rows of each table in use; at least one, at most the table.
  localparam int ROWS_USED = (SEGMENTS < apm_pkg::TABLE_ROWS) ?
                             ((SEGMENTS < 1) ? 1 : SEGMENTS) : apm_pkg::TABLE_ROWS;
  localparam int DIV_TOP0  = apm_pkg::Q_W - 1;
  localparam int DIV_TOP1  = DIV_TOP0 - apm_pkg::DIV_STEPS;
  localparam int DIV_TOP2  = DIV_TOP1 - apm_pkg::DIV_STEPS;

  logic              seg_valid, seg_ready;
  apm_pkg::seg_pl_t  seg_pl;
  logic              scl_valid, scl_ready;
  apm_pkg::div_pl_t  scl_pl;
  logic              dv0_valid, dv0_ready;
  apm_pkg::div_pl_t  dv0_pl;
  logic              dv1_valid, dv1_ready;
  apm_pkg::div_pl_t  dv1_pl;
  logic              dv2_valid, dv2_ready;
  apm_pkg::div_pl_t  dv2_pl;

  logic                        out_valid_q;
  logic [apm_pkg::AQI_W-1:0]   aqi_q, aqi_d;
  logic [apm_pkg::AQI_W-1:0]   sum;

  // Segment lookup: choose the row and form C - Cl
  apm_seg_lookup #(
    .ROWS_USED (ROWS_USED)
  ) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pm10_i  (s_axis_tuser[0]),
    .conc_i  (s_axis_tdata),
    .valid_o (seg_valid),
    .ready_i (seg_ready),
    .pl_o    (seg_pl)
  );

  // Multiply by the index span, add the half-up rounding term
  apm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_valid),
    .ready_o (seg_ready),
    .pl_i    (seg_pl),
    .valid_o (scl_valid),
    .ready_i (scl_ready),
    .pl_o    (scl_pl)
  );

  // Restoring divider, three quotient bits per stage
  apm_div_stage #(
    .TOP_BIT (DIV_TOP0)
  ) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .ready_o (scl_ready),
    .pl_i    (scl_pl),
    .valid_o (dv0_valid),
    .ready_i (dv0_ready),
    .pl_o    (dv0_pl)
  );

  apm_div_stage #(
    .TOP_BIT (DIV_TOP1)
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv0_valid),
    .ready_o (dv0_ready),
    .pl_i    (dv0_pl),
    .valid_o (dv1_valid),
    .ready_i (dv1_ready),
    .pl_o    (dv1_pl)
  );

  apm_div_stage #(
    .TOP_BIT (DIV_TOP2)
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv1_valid),
    .ready_o (dv1_ready),
    .pl_i    (dv1_pl),
    .valid_o (dv2_valid),
    .ready_i (dv2_ready),
    .pl_o    (dv2_pl)
  );

  // Output register: take a new result when empty or when the current one
  // transfers; otherwise hold.
  assign dv2_ready = !out_valid_q || m_axis_tready;

  // Add the lower index, clamp to 500, replace a negative input by -1.
  always_comb begin
    sum = apm_pkg::AQI_W'(dv2_pl.i_lo) + apm_pkg::AQI_W'(dv2_pl.quot);
    if (dv2_pl.invalid) begin
      aqi_d = apm_pkg::AQI_INVALID;
    end else if (dv2_pl.sat || (sum > apm_pkg::AQI_MAX)) begin
      aqi_d = apm_pkg::AQI_MAX;
    end else begin
      aqi_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dv2_ready) begin
      out_valid_q <= dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv2_ready && dv2_valid) begin
      aqi_q <= aqi_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - apm_pkg::AQI_W)'(0), aqi_q};

  // An empty output register must let the whole pipeline move.
  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready
  ) else $error("input stalled while output register empty");

  // A result is either a valid index or the invalid marker.
  a_aqi_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[9:0] <= apm_pkg::AQI_MAX) ||
                       (m_axis_tdata[9:0] == apm_pkg::AQI_INVALID))
  ) else $error("aqi outside 0..500 and not -1");

  // A saturated quotient on a valid concentration must land as 500.
  a_sat_clamps : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (dv2_ready && dv2_valid && dv2_pl.sat && !dv2_pl.invalid) |=>
      (m_axis_tdata[9:0] == apm_pkg::AQI_MAX)
  ) else $error("saturated item did not clamp to 500");

endmodule

FILE: rtl/apm_seg_lookup.sv
// Segment lookup stage: picks the breakpoint row that holds the concentration.
// Uses apm_pkg tables and payload types.
module apm_seg_lookup #(
  parameter int ROWS_USED = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         pm10_i,
  input  logic [apm_pkg::CONC_W-1:0]   conc_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output apm_pkg::seg_pl_t             pl_o
);

  logic                        valid_q;
  apm_pkg::seg_pl_t            pl_q, pl_d;
  logic [apm_pkg::IDX_W-1:0]   idx;
  apm_pkg::seg_t               row;
  apm_pkg::seg_t               cand;

  assign ready_o = !valid_q || ready_i;

  // Rows abut and rise, so the last row whose lower bound is reached holds C;
  // anything past the last row used extrapolates along that row.
  always_comb begin
    idx  = '0;
    cand = '0;
    for (int j = 1; j < ROWS_USED; j++) begin
      cand = pm10_i ? apm_pkg::PM10_TAB[j] : apm_pkg::PM25_TAB[j];
      if (conc_i[apm_pkg::DIFF_W-1:0] >= apm_pkg::DIFF_W'(cand.c_lo)) begin
        idx = apm_pkg::IDX_W'(j);
      end
    end
    row = pm10_i ? apm_pkg::PM10_TAB[idx] : apm_pkg::PM25_TAB[idx];
    pl_d.invalid = conc_i[apm_pkg::CONC_W-1];
    pl_d.diff    = conc_i[apm_pkg::DIFF_W-1:0] - apm_pkg::DIFF_W'(row.c_lo);
    pl_d.den     = row.den;
    pl_d.i_lo    = row.i_lo;
    pl_d.di      = row.di;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pl_q <= pl_d;
    end
  end

  assign valid_o = valid_q;
  assign pl_o    = pl_q;

endmodule

FILE: rtl/apm_scale.sv
// Scale stage: forms the rounded dividend 2*(Ih-Il)*(C-Cl) + den and divisor 2*den.
// Uses apm_pkg payload types.
module apm_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  apm_pkg::seg_pl_t  pl_i,
  output logic              valid_o,
  input  logic              ready_i,
  output apm_pkg::div_pl_t  pl_o
);

  logic                        valid_q;
  apm_pkg::div_pl_t            pl_q, pl_d;
  logic [apm_pkg::NUM_W-1:0]   num;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    num         = apm_pkg::NUM_W'(pl_i.di) * apm_pkg::NUM_W'(pl_i.diff);
    pl_d.invalid = pl_i.invalid;
    pl_d.sat     = 1'b0;
    pl_d.rem     = {num, 1'b0} + apm_pkg::REM_W'(pl_i.den);
    pl_d.dvs     = {pl_i.den, 1'b0};
    pl_d.quot    = '0;
    pl_d.i_lo    = pl_i.i_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pl_q <= pl_d;
    end
  end

  assign valid_o = valid_q;
  assign pl_o    = pl_q;

endmodule

FILE: rtl/apm_div_stage.sv
// One stage of the restoring divider: resolves DIV_STEPS quotient bits from TOP_BIT down.
// Uses apm_pkg payload types.
module apm_div_stage #(
  parameter int TOP_BIT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  apm_pkg::div_pl_t  pl_i,
  output logic              valid_o,
  input  logic              ready_i,
  output apm_pkg::div_pl_t  pl_o
);

  logic                        valid_q;
  apm_pkg::div_pl_t            pl_q, pl_d;
  logic [apm_pkg::REM_W-1:0]   dsh;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    pl_d = pl_i;
    // A quotient past the bits still to come means the index is past 500;
    // only the top stage can see this first, later it fires only on an item already saturated.
    dsh = apm_pkg::REM_W'(pl_i.dvs) << (TOP_BIT + 1);
    if (pl_i.rem >= dsh) begin
      pl_d.sat = 1'b1;
    end
    for (int s = 0; s < apm_pkg::DIV_STEPS; s++) begin
      dsh = apm_pkg::REM_W'(pl_i.dvs) << (TOP_BIT - s);
      if (pl_d.rem >= dsh) begin
        pl_d.rem                 = pl_d.rem - dsh;
        pl_d.quot[TOP_BIT - s]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pl_q <= pl_d;
    end
  end

  assign valid_o = valid_q;
  assign pl_o    = pl_q;

endmodule
